[sv/solu_pkg.sv]
// solu_pkg: shared types and codes for the self-organizing list lookup.
// Used by solu_cell and self_organizing_list_lookup; no dependencies.
package solu_pkg;

  localparam int unsigned SIZE_BITS = 7;

  typedef enum logic [1:0] {
    STRAT_SEQ   = 2'd0,
    STRAT_MTF   = 2'd1,
    STRAT_TRANS = 2'd2,
    STRAT_COUNT = 2'd3
  } strategy_e;

  typedef enum logic {
    REG_STRATEGY = 1'b0,
    REG_SIZE     = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic                 load;
    logic [SIZE_BITS-1:0] size;
  } ctrl_t;

endpackage

[sv/solu_cell.sv]
// solu_cell: one list entry (key and hit count) with compare and neighbor shift.
// Depends on solu_pkg.
module solu_cell #(
  parameter int unsigned IDX      = 0,
  parameter int unsigned KEY_BITS = 32,
  parameter int unsigned HIT_BITS = 16
) (
  input  logic                clk_i,
  input  solu_pkg::ctrl_t     ctrl_i,
  input  logic                shift_i,
  input  logic                take_i,
  input  logic [KEY_BITS-1:0] left_key_i,
  input  logic [HIT_BITS-1:0] left_hits_i,
  input  logic [KEY_BITS-1:0] new_key_i,
  input  logic [HIT_BITS-1:0] new_hits_i,
  input  logic [KEY_BITS-1:0] cmp_key_i,
  output logic [KEY_BITS-1:0] key_o,
  output logic [HIT_BITS-1:0] hits_o,
  output logic                match_o,
  output logic                le_o
);

  logic [KEY_BITS-1:0] key_q;
  logic [HIT_BITS-1:0] hits_q;
  logic                in_load;

  assign in_load = 32'(ctrl_i.size) > IDX;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      key_q  <= in_load ? KEY_BITS'(IDX + 1) : '0;
      hits_q <= '0;
    end else if (take_i) begin
      key_q  <= new_key_i;
      hits_q <= new_hits_i;
    end else if (shift_i) begin
      key_q  <= left_key_i;
      hits_q <= left_hits_i;
    end
  end

  assign key_o   = key_q;
  assign hits_o  = hits_q;
  assign match_o = key_q == cmp_key_i;
  assign le_o    = hits_q <= new_hits_i;

endmodule

[sv/self_organizing_list_lookup.sv]
// self_organizing_list_lookup: top level, a chain of solu_cell entries and the
// lookup sequencer. Depends on solu_pkg and solu_cell.
//
// Each accepted key word passes through a compare, a select and an update step.
// The compare step checks the key in all cells and picks the first hit. The
// select step registers that entry's position and hit count. The update step is
// one reorder/insert step in which the target cell takes the new entry and the
// cells after it up to the end slot load from their left neighbor. The block is
// ready for a new word once the result appears, and takes none while an earlier
// word is in flight. While an earlier result is still unread, the update step
// waits. Writing the size register reloads the whole list. No clearing pass after reset.
module self_organizing_list_lookup #(
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned KEY_BITS = 32,
  parameter int unsigned HIT_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [6:0]          cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [KEY_BITS-1:0] key_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [6:0]          comparisons_o,
  output logic                found_o,
  output logic                full_dropped_o
);

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam logic [HIT_BITS-1:0] HIT_MAX = '1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMP  = 2'd1;
  localparam logic [1:0] ST_SEL  = 2'd2;
  localparam logic [1:0] ST_UPD  = 2'd3;

  logic [1:0] state_q, state_d;
  logic [1:0] strat_q;
  logic [CNT_W-1:0] occ_q;
  logic [KEY_BITS-1:0] key_q;
  logic [CAPACITY-1:0] hit_oh_q;
  logic hit_q;
  logic [IDX_W-1:0] pos_q;
  logic [HIT_BITS-1:0] newc_q;
  logic out_valid_q;
  logic [6:0] comps_q;
  logic found_q, drop_q;

  solu_pkg::ctrl_t ctrl;
  logic [KEY_BITS-1:0] cell_key [CAPACITY];
  logic [HIT_BITS-1:0] cell_hits [CAPACITY];
  logic [CAPACITY-1:0] match, le, valid, shift, take, hit_oh;
  logic [HIT_BITS-1:0] new_hits, sel_hits;
  logic [IDX_W-1:0] pos;
  logic [CNT_W-1:0] lim, d_idx, e_idx;
  logic drop, do_upd;
  logic [CNT_W:0] size_clip;

  assign ctrl.load = cfg_we_i && (cfg_idx_i == solu_pkg::REG_SIZE);
  assign ctrl.size = cfg_data_i;
  assign new_hits  = hit_q ? newc_q : '0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    solu_cell #(
      .IDX(g), .KEY_BITS(KEY_BITS), .HIT_BITS(HIT_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .shift_i    (shift[g]),
      .take_i     (take[g]),
      .left_key_i ((g == 0) ? '0 : cell_key[(g == 0) ? 0 : g-1]),
      .left_hits_i((g == 0) ? '0 : cell_hits[(g == 0) ? 0 : g-1]),
      .new_key_i  (key_q),
      .new_hits_i (new_hits),
      .cmp_key_i  (key_q),
      .key_o      (cell_key[g]),
      .hits_o     (cell_hits[g]),
      .match_o    (match[g]),
      .le_o       (le[g])
    );
    assign valid[g] = 32'(occ_q) > g;
  end

  // first hit from the front
  always_comb begin
    logic seen;
    seen = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_oh[i] = match[i] && valid[i] && !seen;
      seen = seen || (match[i] && valid[i]);
    end
  end

  always_comb begin
    sel_hits = '0;
    pos      = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      sel_hits = sel_hits | (cell_hits[i] & {HIT_BITS{hit_oh_q[i]}});
      pos      = pos | (IDX_W'(i) & {IDX_W{hit_oh_q[i]}});
    end
  end

  // target slot d and end slot e; cells in (d, e] shift, cell d takes the entry
  always_comb begin
    logic [CNT_W-1:0] first;
    lim   = hit_q ? CNT_W'(pos_q) : occ_q;
    first = lim;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (le[i] && (CNT_W'(i) < lim)) first = CNT_W'(i);
    end
    e_idx = lim;
    unique case (solu_pkg::strategy_e'(strat_q))
      solu_pkg::STRAT_SEQ:   d_idx = lim;
      solu_pkg::STRAT_MTF:   d_idx = '0;
      solu_pkg::STRAT_TRANS: d_idx = (hit_q && lim != '0) ? lim - 1'b1 : (hit_q ? lim : '0);
      solu_pkg::STRAT_COUNT: d_idx = first;
      default:               d_idx = lim;
    endcase
    drop   = !hit_q && (32'(occ_q) >= CAPACITY);
    do_upd = (state_q == ST_UPD) && (!out_valid_q || out_ready_i) && !drop;
    for (int i = 0; i < CAPACITY; i++) begin
      take[i]  = do_upd && (CNT_W'(i) == d_idx);
      shift[i] = do_upd && (CNT_W'(i) > d_idx) && (CNT_W'(i) <= e_idx);
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_CMP;
      ST_CMP:  state_d = ST_SEL;
      ST_SEL:  state_d = ST_UPD;
      ST_UPD:  if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  assign size_clip = (32'(cfg_data_i) > CAPACITY) ? (CNT_W+1)'(CAPACITY)
                                                 : (CNT_W+1)'(cfg_data_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      strat_q     <= solu_pkg::STRAT_MTF;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i && cfg_idx_i == solu_pkg::REG_STRATEGY) strat_q <= cfg_data_i[1:0];
      if (ctrl.load) begin
        occ_q <= size_clip[CNT_W-1:0];
      end else if (do_upd && !hit_q) begin
        occ_q <= occ_q + 1'b1;
      end
      if (state_q == ST_UPD && state_d == ST_IDLE) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) key_q <= key_i;
    if (state_q == ST_CMP) begin
      hit_oh_q <= hit_oh;
      hit_q    <= |(match & valid);
    end
    if (state_q == ST_SEL) begin
      pos_q   <= pos;
      newc_q  <= (sel_hits == HIT_MAX) ? sel_hits : sel_hits + 1'b1;
      comps_q <= hit_q ? 7'(32'(pos) + 1) : 7'(occ_q);
    end
    if (state_q == ST_UPD && state_d == ST_IDLE) begin
      comparisons_o <= comps_q;
      found_q       <= hit_q;
      drop_q        <= drop;
    end
  end

  assign in_ready_o     = state_q == ST_IDLE;
  assign out_valid_o    = out_valid_q;
  assign found_o        = found_q;
  assign full_dropped_o = drop_q;

`ifndef SYNTH
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(occ_q) <= CAPACITY) else $error("occupancy above capacity");
  a_drop_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(found_o && full_dropped_o)) else $error("drop on hit");
  a_hit_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SEL |-> $onehot0(hit_oh_q)) else $error("multiple first hits");
  a_upd_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_upd |=> !do_upd) else $error("double update");
`endif

endmodule
